// ===== rtl/rsg_pkg.sv =====
package rsg_pkg;

  localparam int MOTOR_COUNT = 3;
  localparam int MOTOR_W     = 2;
  localparam int LINE_W      = 3;
  localparam int DIST_W      = 10;
  localparam int SPM_W       = 8;
  localparam int TIME_W      = 16;
  localparam int STEPS_W     = 18;
  localparam int ERR_W       = 20;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOW,
    PH_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    REG_STEPS_PER_MM,
    REG_START_DELAY,
    REG_MIN_DELAY,
    REG_ACCEL_STEP,
    REG_PULSE_HIGH
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK,
    KIND_MOVE
  } kind_t;

  typedef struct packed {
    logic [SPM_W-1:0]  steps_per_mm;
    logic [TIME_W-1:0] start_delay_us;
    logic [TIME_W-1:0] delay_floor;
    logic [TIME_W-1:0] delay_dec;
    logic [TIME_W-1:0] pulse_high_us;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [MOTOR_W-1:0] motor_a;
    logic              dir_a;
    logic [MOTOR_W-1:0] motor_b;
    logic              dir_b;
    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] step_lines;
    logic [LINE_W-1:0] dir_lines;
    logic              busy_res;
    logic              move_done;
    logic              rejected;
  } out_item_t;

  // one-hot line mask for a motor, empty when the motor does not exist
  function automatic logic [LINE_W-1:0] motor_bit(input logic [MOTOR_W-1:0] motor);
    logic [LINE_W-1:0] m;
    m = '0;
    if (int'(motor) < MOTOR_COUNT && int'(motor) < LINE_W) begin
      m = LINE_W'(1) << motor;
    end
    return m;
  endfunction

  // phase lengths of zero are stretched to one tick
  function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
    return (v == '0) ? TIME_W'(1) : v;
  endfunction

endpackage

// ===== rtl/rsg_if.sv =====
interface rsg_in_if;
  logic              valid;
  logic              ready;
  rsg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsg_out_if;
  logic               valid;
  logic               ready;
  rsg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rsg_cfg_regs.sv =====
module rsg_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsg_pkg::ADDR_W-1:0] paddr,
  input  logic [rsg_pkg::DATA_W-1:0] pwdata,
  output logic [rsg_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rsg_pkg::cfg_t              cfg
);

  rsg_pkg::cfg_t     cfg_r;
  rsg_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = rsg_pkg::reg_idx_t'(paddr[rsg_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps_per_mm   <= rsg_pkg::SPM_W'(80);
      cfg_r.start_delay_us <= rsg_pkg::TIME_W'(2000);
      cfg_r.delay_floor    <= rsg_pkg::TIME_W'(500);
      cfg_r.delay_dec      <= rsg_pkg::TIME_W'(10);
      cfg_r.pulse_high_us  <= rsg_pkg::TIME_W'(10);
    end else if (wr_en) begin
      case (idx)
        rsg_pkg::REG_STEPS_PER_MM: cfg_r.steps_per_mm   <= pwdata[rsg_pkg::SPM_W-1:0];
        rsg_pkg::REG_START_DELAY:  cfg_r.start_delay_us <= pwdata[rsg_pkg::TIME_W-1:0];
        rsg_pkg::REG_MIN_DELAY:    cfg_r.delay_floor    <= pwdata[rsg_pkg::TIME_W-1:0];
        rsg_pkg::REG_ACCEL_STEP:   cfg_r.delay_dec      <= pwdata[rsg_pkg::TIME_W-1:0];
        rsg_pkg::REG_PULSE_HIGH:   cfg_r.pulse_high_us  <= pwdata[rsg_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    case (idx)
      rsg_pkg::REG_STEPS_PER_MM: prdata = rsg_pkg::DATA_W'(cfg_r.steps_per_mm);
      rsg_pkg::REG_START_DELAY:  prdata = rsg_pkg::DATA_W'(cfg_r.start_delay_us);
      rsg_pkg::REG_MIN_DELAY:    prdata = rsg_pkg::DATA_W'(cfg_r.delay_floor);
      rsg_pkg::REG_ACCEL_STEP:   prdata = rsg_pkg::DATA_W'(cfg_r.delay_dec);
      rsg_pkg::REG_PULSE_HIGH:   prdata = rsg_pkg::DATA_W'(cfg_r.pulse_high_us);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/rsg_core.sv =====
module rsg_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  rsg_pkg::in_item_t  item,
  input  rsg_pkg::cfg_t      cfg,
  output rsg_pkg::out_item_t res
);

  localparam int EXT_ERR = rsg_pkg::ERR_W - rsg_pkg::STEPS_W;

  rsg_pkg::phase_t                    phase_r, phase_nxt;
  logic [rsg_pkg::TIME_W-1:0]         timer_r, timer_nxt;
  logic [rsg_pkg::TIME_W-1:0]         delay_r, delay_nxt;
  logic [rsg_pkg::STEPS_W-1:0]        prim_rem_r, prim_rem_nxt;
  logic [rsg_pkg::STEPS_W-1:0]        prim_tot_r, prim_tot_nxt;
  logic [rsg_pkg::STEPS_W-1:0]        sec_tot_r, sec_tot_nxt;
  logic signed [rsg_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic [rsg_pkg::MOTOR_W-1:0]        pm_r, pm_nxt;
  logic [rsg_pkg::MOTOR_W-1:0]        sm_r, sm_nxt;
  logic                               pd_r, pd_nxt;
  logic                               sd_r, sd_nxt;
  logic                               on_sec_r, on_sec_nxt;
  logic [rsg_pkg::LINE_W-1:0]         step_r, step_nxt;
  logic [rsg_pkg::LINE_W-1:0]         dir_r, dir_nxt;

  logic [rsg_pkg::STEPS_W-1:0]        steps_a, steps_b;
  logic [rsg_pkg::TIME_W-1:0]         tmr_dec;
  logic signed [rsg_pkg::ERR_W-1:0]   err_sum;
  logic signed [rsg_pkg::ERR_W:0]     err_twice;
  logic signed [rsg_pkg::ERR_W:0]     tot_ext;
  logic                               bp;
  logic [rsg_pkg::MOTOR_W-1:0]        bp_motor;
  logic                               bp_dir;
  logic [rsg_pkg::LINE_W-1:0]         bp_bit;
  logic                               done;
  logic                               rej;

  // step counts of both axes
  assign steps_a = rsg_pkg::STEPS_W'(item.dist_a) * rsg_pkg::STEPS_W'(cfg.steps_per_mm);
  assign steps_b = rsg_pkg::STEPS_W'(item.dist_b) * rsg_pkg::STEPS_W'(cfg.steps_per_mm);

  // Bresenham error term
  assign tmr_dec   = timer_r - rsg_pkg::TIME_W'(1);
  assign err_sum   = err_r + $signed({{EXT_ERR{1'b0}}, sec_tot_r});
  assign err_twice = {err_sum, 1'b0};
  assign tot_ext   = $signed({{(EXT_ERR + 1){1'b0}}, prim_tot_r});

  // next state for one beat
  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    delay_nxt    = delay_r;
    prim_rem_nxt = prim_rem_r;
    prim_tot_nxt = prim_tot_r;
    sec_tot_nxt  = sec_tot_r;
    err_nxt      = err_r;
    pm_nxt       = pm_r;
    sm_nxt       = sm_r;
    pd_nxt       = pd_r;
    sd_nxt       = sd_r;
    on_sec_nxt   = on_sec_r;
    step_nxt     = step_r;
    dir_nxt      = dir_r;
    bp           = 1'b0;
    bp_motor     = pm_r;
    bp_dir       = pd_r;
    done         = 1'b0;
    rej          = 1'b0;

    if (item.kind == rsg_pkg::KIND_MOVE) begin
      if (phase_r != rsg_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        if (steps_a > steps_b) begin
          pm_nxt = item.motor_a; pd_nxt = item.dir_a; prim_tot_nxt = steps_a;
          sm_nxt = item.motor_b; sd_nxt = item.dir_b; sec_tot_nxt  = steps_b;
        end else begin
          pm_nxt = item.motor_b; pd_nxt = item.dir_b; prim_tot_nxt = steps_b;
          sm_nxt = item.motor_a; sd_nxt = item.dir_a; sec_tot_nxt  = steps_a;
        end
        if (prim_tot_nxt == '0) begin
          done = 1'b1;
        end else begin
          prim_rem_nxt = prim_tot_nxt;
          err_nxt      = '0;
          delay_nxt    = cfg.start_delay_us;
          on_sec_nxt   = 1'b0;
          bp           = 1'b1;
          bp_motor     = pm_nxt;
          bp_dir       = pd_nxt;
        end
      end
    end else if (phase_r == rsg_pkg::PH_LOW) begin
      timer_nxt = tmr_dec;
      if (tmr_dec == '0) begin
        step_nxt  = step_r | rsg_pkg::motor_bit(on_sec_r ? sm_r : pm_r);
        phase_nxt = rsg_pkg::PH_HIGH;
        timer_nxt = rsg_pkg::at_least_one(cfg.pulse_high_us);
      end
    end else if (phase_r == rsg_pkg::PH_HIGH) begin
      timer_nxt = tmr_dec;
      if (tmr_dec == '0) begin
        // ramp the delay towards the floor
        if (delay_r > cfg.delay_floor) begin
          if (delay_r - cfg.delay_floor > cfg.delay_dec) begin
            delay_nxt = delay_r - cfg.delay_dec;
          end else begin
            delay_nxt = cfg.delay_floor;
          end
        end
        if (!on_sec_r) begin
          prim_rem_nxt = prim_rem_r - rsg_pkg::STEPS_W'(1);
          err_nxt      = err_sum;
          if (err_twice >= tot_ext) begin
            err_nxt    = err_sum - $signed({{EXT_ERR{1'b0}}, prim_tot_r});
            on_sec_nxt = 1'b1;
            bp         = 1'b1;
            bp_motor   = sm_r;
            bp_dir     = sd_r;
          end
        end else begin
          on_sec_nxt = 1'b0;
        end
        if (!bp) begin
          if (prim_rem_nxt == '0) begin
            phase_nxt = rsg_pkg::PH_IDLE;
            timer_nxt = '0;
            done      = 1'b1;
          end else begin
            bp       = 1'b1;
            bp_motor = pm_r;
            bp_dir   = pd_r;
          end
        end
      end
    end

    // pulse start: direction set, step line low, low phase armed
    bp_bit = rsg_pkg::motor_bit(bp_motor);
    if (bp) begin
      dir_nxt   = bp_dir ? (dir_nxt | bp_bit) : (dir_nxt & ~bp_bit);
      step_nxt  = step_nxt & ~bp_bit;
      phase_nxt = rsg_pkg::PH_LOW;
      timer_nxt = rsg_pkg::at_least_one(delay_nxt);
    end

    res.step_lines = step_nxt;
    res.dir_lines  = dir_nxt;
    res.busy_res   = (phase_nxt != rsg_pkg::PH_IDLE);
    res.move_done  = done;
    res.rejected   = rej;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rsg_pkg::PH_IDLE;
      on_sec_r <= 1'b0;
      step_r   <= '0;
      dir_r    <= '0;
      timer_r  <= '0;
      prim_rem_r <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      on_sec_r <= on_sec_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
      timer_r  <= timer_nxt;
      prim_rem_r <= prim_rem_nxt;
    end
  end

  // move data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= '0;
      prim_tot_r <= '0;
      sec_tot_r  <= '0;
      err_r      <= '0;
      pm_r       <= '0;
      sm_r       <= '0;
      pd_r       <= 1'b0;
      sd_r       <= 1'b0;
    end else if (acc) begin
      delay_r    <= delay_nxt;
      prim_tot_r <= prim_tot_nxt;
      sec_tot_r  <= sec_tot_nxt;
      err_r      <= err_nxt;
      pm_r       <= pm_nxt;
      sm_r       <= sm_nxt;
      pd_r       <= pd_nxt;
      sd_r       <= sd_nxt;
    end
  end

endmodule

// ===== rtl/rsg_out_buf.sv =====
module rsg_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rsg_pkg::out_item_t res,
  output logic               can_take,
  rsg_out_if.source          out_ch
);

  rsg_pkg::out_item_t main_r;
  rsg_pkg::out_item_t skid_r;
  logic               main_vld_r;
  logic               skid_vld_r;
  logic               pop;

  assign can_take     = !skid_vld_r;
  assign pop          = main_vld_r & out_ch.ready;
  assign out_ch.valid = main_vld_r;
  assign out_ch.data  = main_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      if (main_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        main_vld_r <= 1'b1;
      end
    end else if (pop) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= 1'b0;
      end
    end
  end

  // beat data
  always_ff @(posedge clk) begin
    if (push) begin
      if (main_vld_r && !pop) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end else if (pop && skid_vld_r) begin
      main_r <= skid_r;
    end
  end

endmodule

// ===== rtl/two_axis_ramped_step_generator_unit.sv =====
// Ramped two-axis step generator for three stepper motors.
// Input channel in_ch carries one beat per item: a one-microsecond tick
// (kind 0) or a start-move command (kind 1) with two motors, directions and
// distances in millimetres. Output channel out_ch returns exactly one beat
// per input beat: step and direction line levels, busy, move-done and
// move-rejected flags, showing the state after that item.
// Registers sit on the APB port: steps_per_mm at 0x0, start_delay_us 0x4,
// ramp floor 0x8, ramp decrement 0xC, pulse_high_us 0x10. Write them only
// while no move is running and no result is outstanding.
// Throughput is one item per cycle while in_ch.ready is high: all work for an
// item is a single pass through the step engine between its state registers
// and the result register; out_ch is driven from the output buffer registers.
// A two-entry output buffer lets the block take a further item while a
// result waits; when both entries are full in_ch.ready drops until the
// receiver takes a beat. Synchronous reset returns the engine to idle with
// all lines low and the registers at their defaults; no results are held.
module two_axis_ramped_step_generator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  rsg_in_if.sink                     in_ch,
  rsg_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsg_pkg::ADDR_W-1:0] paddr,
  input  logic [rsg_pkg::DATA_W-1:0] pwdata,
  output logic [rsg_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  rsg_pkg::cfg_t      cfg;
  rsg_pkg::out_item_t res;
  logic               can_take;
  logic               acc;

  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid & can_take;

  // configuration registers
  rsg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step engine
  rsg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_ch.data),
    .cfg   (cfg),
    .res   (res)
  );

  // result buffer
  rsg_out_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .res      (res),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // a refused move never clears busy
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.rejected |-> res.busy_res)
    else $error("rejected move with engine idle");

  // a finished move leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.move_done |-> !res.busy_res && !res.rejected)
    else $error("move done while still busy");

  // input stalls only with a result waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !can_take |-> out_ch.valid)
    else $error("input stalled with empty output");

  // the buffer fills only on a push against a stalled output
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(can_take) |-> $past(acc && out_ch.valid && !out_ch.ready))
    else $error("buffer filled without a stalled push");
`endif

endmodule
